// File: rtl/core/cfas_pkg.sv
// ----------------------------------------------------------------------------
// cfas_pkg
// Shared types, constants and helpers for the CAN frame to ASCII serial unit.
// ----------------------------------------------------------------------------
package cfas_pkg;

   // frame geometry
   localparam int MAX_PAYLOAD_BYTES = 8;
   localparam int ID_WIDTH          = 11;
   localparam int LEN_WIDTH         = 4;
   localparam int BYTE_WIDTH        = 8;
   localparam int POS_WIDTH         = 5;

   // character positions inside the frame text
   localparam logic [POS_WIDTH-1:0] POS_START   = 5'd0;
   localparam logic [POS_WIDTH-1:0] POS_ID_HI   = 5'd1;
   localparam logic [POS_WIDTH-1:0] POS_ID_MID  = 5'd2;
   localparam logic [POS_WIDTH-1:0] POS_ID_LO   = 5'd3;
   localparam logic [POS_WIDTH-1:0] POS_LEN     = 5'd4;
   localparam logic [POS_WIDTH-1:0] POS_DATA    = 5'd5;

   // character codes
   localparam logic [7:0] CHAR_START = 8'h74;  // 't'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_ALPHA = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_CR    = 8'h0D;  // carriage return

   typedef logic [BYTE_WIDTH-1:0] byte_type;

   // one input word
   typedef struct packed {
      logic [ID_WIDTH-1:0]                    can_id;
      logic [LEN_WIDTH-1:0]                   data_len;
      logic [MAX_PAYLOAD_BYTES-1:0][BYTE_WIDTH-1:0] data_byte;
   } frame_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_last;
      logic out_free;
   } status_type;

   // upper-case hex digit of a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] code;
      if (nibble < 4'd10) begin
         code = CHAR_ZERO + {4'd0, nibble};
      end else begin
         code = CHAR_ALPHA + {4'd0, nibble - 4'd10};
      end
      return code;
   endfunction

   // clamp the length field to the payload size
   function automatic logic [LEN_WIDTH-1:0] clamp_len(input logic [LEN_WIDTH-1:0] len);
      logic [LEN_WIDTH-1:0] res;
      if (len > LEN_WIDTH'(MAX_PAYLOAD_BYTES)) begin
         res = LEN_WIDTH'(MAX_PAYLOAD_BYTES);
      end else begin
         res = len;
      end
      return res;
   endfunction

endpackage

// File: rtl/core/cfas_if.sv
// ----------------------------------------------------------------------------
// cfas channel interfaces
// Valid/ready channels for incoming CAN frames and outgoing ASCII characters.
// ----------------------------------------------------------------------------
interface cfas_req_if import cfas_pkg::*; ();
   logic                                         valid;
   logic                                         ready;
   logic [ID_WIDTH-1:0]                          can_id;
   logic [LEN_WIDTH-1:0]                         data_len;
   logic [BYTE_WIDTH-1:0]                        data_byte_0;
   logic [BYTE_WIDTH-1:0]                        data_byte_1;
   logic [BYTE_WIDTH-1:0]                        data_byte_2;
   logic [BYTE_WIDTH-1:0]                        data_byte_3;
   logic [BYTE_WIDTH-1:0]                        data_byte_4;
   logic [BYTE_WIDTH-1:0]                        data_byte_5;
   logic [BYTE_WIDTH-1:0]                        data_byte_6;
   logic [BYTE_WIDTH-1:0]                        data_byte_7;

   modport source (
      output valid, can_id, data_len, data_byte_0, data_byte_1, data_byte_2,
             data_byte_3, data_byte_4, data_byte_5, data_byte_6, data_byte_7,
      input  ready
   );
   modport sink (
      input  valid, can_id, data_len, data_byte_0, data_byte_1, data_byte_2,
             data_byte_3, data_byte_4, data_byte_5, data_byte_6, data_byte_7,
      output ready
   );
endinterface

interface cfas_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] ascii_char;
   logic       last_char;

   modport source (output valid, ascii_char, last_char, input ready);
   modport sink (input valid, ascii_char, last_char, output ready);
endinterface

// File: rtl/core/cfas_ctrl.sv
// ----------------------------------------------------------------------------
// cfas_ctrl
// Controller: takes a frame, then steps the datapath one character at a time.
// ----------------------------------------------------------------------------
module cfas_ctrl
   import cfas_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      advance;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      advance   = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EMIT: begin
            advance   = status.out_free;
            // next frame may load while the carriage return goes out
            req_ready = status.out_free & status.at_last;
         end
         default: begin
            advance   = 1'b0;
            req_ready = 1'b0;
         end
      endcase
      cmd.advance = advance;
      cmd.load    = req_valid & req_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.at_last && !req_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/cfas_dpath.sv
// ----------------------------------------------------------------------------
// cfas_dpath
// Datapath: holds the frame, picks the character at the current position and
// keeps it in the output register.
// ----------------------------------------------------------------------------
module cfas_dpath
   import cfas_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  frame_type  frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] ascii_char,
   output logic       last_char
);

   localparam int BIDX_WIDTH = $clog2(MAX_PAYLOAD_BYTES) > 0 ? $clog2(MAX_PAYLOAD_BYTES) : 1;

   logic [ID_WIDTH-1:0]                          id_ff;
   logic [LEN_WIDTH-1:0]                         len_ff;
   logic [MAX_PAYLOAD_BYTES-1:0][BYTE_WIDTH-1:0] payload_ff;
   logic [POS_WIDTH-1:0]                         pos_ff;
   logic [POS_WIDTH-1:0]                         pos_in;
   logic                                         valid_ff;
   logic                                         valid_in;
   logic [7:0]                                   char_ff;
   logic                                         last_ff;

   logic [POS_WIDTH-1:0]                         last_pos;
   logic [POS_WIDTH-1:0]                         data_off;
   logic [BIDX_WIDTH-1:0]                        byte_idx;
   logic [BYTE_WIDTH-1:0]                        cur_byte;
   logic [7:0]                                   char_sel;
   logic                                         at_last;

   // frame holding registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff      <= frame.can_id;
         len_ff     <= clamp_len(frame.data_len);
         payload_ff <= frame.data_byte;
      end
   end

   // character position
   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = POS_START;
      end else if (cmd.advance) begin
         pos_in = pos_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_START;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // character select for the current position
   always_comb begin
      last_pos = POS_DATA + {len_ff, 1'b0};
      data_off = pos_ff - POS_DATA;
      byte_idx = data_off[BIDX_WIDTH:1];
      cur_byte = payload_ff[byte_idx];
      at_last  = (pos_ff == last_pos);
      case (pos_ff)
         POS_START:  char_sel = CHAR_START;
         POS_ID_HI:  char_sel = hex_digit({1'b0, id_ff[10:8]});
         POS_ID_MID: char_sel = hex_digit(id_ff[7:4]);
         POS_ID_LO:  char_sel = hex_digit(id_ff[3:0]);
         POS_LEN:    char_sel = CHAR_ZERO + {4'd0, len_ff};
         default: begin
            if (at_last) begin
               char_sel = CHAR_CR;
            end else if (!data_off[0]) begin
               char_sel = hex_digit(cur_byte[7:4]);
            end else begin
               char_sel = hex_digit(cur_byte[3:0]);
            end
         end
      endcase
   end

   // output register
   always_comb begin
      valid_in = valid_ff;
      if (cmd.advance) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         char_ff <= char_sel;
         last_ff <= at_last;
      end
   end

   assign status.at_last  = at_last;
   assign status.out_free = ~valid_ff | rsp_ready;
   assign rsp_valid       = valid_ff;
   assign ascii_char      = char_ff;
   assign last_char       = last_ff;

endmodule

// File: rtl/core/can_frame_to_ascii_serial_unit.sv
// ----------------------------------------------------------------------------
// can_frame_to_ascii_serial_unit
// Turns one standard CAN frame into its ASCII serial text, one character per
// output word.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one frame per word: 11-bit identifier, length (values
//   above 8 count as 8) and eight data bytes. rsp_if returns the text 't',
//   three hex id digits, the length digit, two hex digits per used byte and a
//   carriage return flagged by last_char.
//   A frame with n used bytes gives 6 + 2n characters (6 to 22), one per
//   cycle while the receiver keeps ready high; the character sequencer is
//   the limit. The first character is presented after the frame is latched
//   into the holding registers and its 't' goes into the output register.
//   The next frame is taken in the cycle the carriage return is loaded into
//   the output register, so back-to-back frames stream with no gap.
//   Reset (synchronous) drops any frame in progress and clears rsp valid.
//   When the receiver stalls, the output register holds its character and
//   the sequencer waits; no character is lost or repeated.
// ----------------------------------------------------------------------------
module can_frame_to_ascii_serial_unit
   import cfas_pkg::*;
(
   input logic            clock,
   input logic            reset,
   cfas_req_if.sink       req_if,
   cfas_rsp_if.source     rsp_if
);

   cmd_type    cmd;
   status_type status;
   frame_type  frame;

   // gather the input word
   always_comb begin
      frame.can_id       = req_if.can_id;
      frame.data_len     = req_if.data_len;
      frame.data_byte[0] = req_if.data_byte_0;
      frame.data_byte[1] = req_if.data_byte_1;
      frame.data_byte[2] = req_if.data_byte_2;
      frame.data_byte[3] = req_if.data_byte_3;
      frame.data_byte[4] = req_if.data_byte_4;
      frame.data_byte[5] = req_if.data_byte_5;
      frame.data_byte[6] = req_if.data_byte_6;
      frame.data_byte[7] = req_if.data_byte_7;
   end

   cfas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfas_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .frame      (frame),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .ascii_char (rsp_if.ascii_char),
      .last_char  (rsp_if.last_char)
   );

endmodule

// File: rtl/core/cfas_checker.sv
// ----------------------------------------------------------------------------
// cfas_checker
// Port-level checks for the CAN frame to ASCII serial unit.
// ----------------------------------------------------------------------------
module cfas_checker
   import cfas_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] ascii_char,
   input logic       last_char
);

   // stalled output word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(ascii_char) && $stable(last_char))
      else $error("stalled output word changed");

   // last flag marks exactly the carriage return
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_char == (ascii_char == CHAR_CR)))
      else $error("last flag and carriage return disagree");

   // a taken frame blocks the input until its text is nearly out
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a frame was taken");

   // reset leaves no output word pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind can_frame_to_ascii_serial_unit cfas_checker u_cfas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .ascii_char (rsp_if.ascii_char),
   .last_char  (rsp_if.last_char)
);
